[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sem_pkg.sv]
// Shared constants and types of the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int WREG_W     = 11;
    localparam int HREG_W     = 13;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int WIN_N      = 9;
    localparam int ROOT_STEPS = 8;
    localparam int STEP_W     = 3;
    localparam int SQ_W       = 21;

    localparam logic [SQ_W-1:0]   SAT_LIMIT = 21'd65280;
    localparam logic [CH_W-1:0]   MAG_MAX   = 8'd255;
    localparam logic [WREG_W-1:0] WIDTH_RST = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic [2:0] ADDR_IMAGE_WIDTH  = 3'h0;
    localparam logic [2:0] ADDR_IMAGE_HEIGHT = 3'h4;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } top_state_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_SQUARE,
        LS_ROOT,
        LS_DONE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctrl_t;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] mag;
    } lane_stat_t;

endpackage

`default_nettype wire

[design/sem_line_store.sv]
// Two line stores holding the two image rows above the current input row.
`timescale 1ns / 1ps
`default_nettype none

module sem_line_store (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [sem_pkg::COL_W-1:0] rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [sem_pkg::COL_W-1:0] wr_addr,
    input  wire sem_pkg::pixel_t           wr_prev,
    input  wire sem_pkg::pixel_t           wr_old,
    output sem_pkg::pixel_t                rd_prev,
    output sem_pkg::pixel_t                rd_old
);
    import sem_pkg::*;

    pixel_t prev_mem [MAX_WIDTH];
    pixel_t old_mem  [MAX_WIDTH];
    pixel_t rd_prev_reg;
    pixel_t rd_old_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_mem[wr_addr] <= wr_prev;
            old_mem[wr_addr]  <= wr_old;
        end
        if (rd_en)
        begin
            rd_prev_reg <= prev_mem[rd_addr];
            rd_old_reg  <= old_mem[rd_addr];
        end
    end

    assign rd_prev = rd_prev_reg;
    assign rd_old  = rd_old_reg;

endmodule

`default_nettype wire

[design/sem_lane.sv]
// One channel lane: Sobel gradients, squared sum and rounded square root.
`timescale 1ns / 1ps
`default_nettype none

module sem_lane (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sem_pkg::lane_ctrl_t      ctrl,
    input  wire logic [sem_pkg::CH_W-1:0] taps [sem_pkg::WIN_N],
    output sem_pkg::lane_stat_t           stat
);
    import sem_pkg::*;

    lane_state_t         state_reg, state_next;
    logic signed [11:0]  gx_reg, gy_reg;
    logic signed [11:0]  gx_c, gy_c;
    logic [SQ_W-1:0]     sq_c;
    logic                sat_reg;
    logic [15:0]         rad_reg;
    logic [9:0]          rem_reg;
    logic [CH_W-1:0]     root_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [11:0]         rem_sh;
    logic [11:0]         trial;
    logic [CH_W:0]       rounded;

    // Gradients from the 3x3 taps, row-major order
    always_comb
    begin
        gx_c = $signed({4'b0000, taps[2]} + {3'b000, taps[5], 1'b0} + {4'b0000, taps[8]})
             - $signed({4'b0000, taps[0]} + {3'b000, taps[3], 1'b0} + {4'b0000, taps[6]});
        gy_c = $signed({4'b0000, taps[6]} + {3'b000, taps[7], 1'b0} + {4'b0000, taps[8]})
             - $signed({4'b0000, taps[0]} + {3'b000, taps[1], 1'b0} + {4'b0000, taps[2]});
    end

    logic signed [23:0] gx_sq, gy_sq;
    assign gx_sq = 24'(gx_reg) * 24'(gx_reg);
    assign gy_sq = 24'(gy_reg) * 24'(gy_reg);
    assign sq_c  = gx_sq[SQ_W-1:0] + gy_sq[SQ_W-1:0];

    assign rem_sh = {rem_reg, rad_reg[15:14]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign rounded = ({2'b00, rem_reg} > {4'b0000, root_reg}) ?
                     {1'b0, root_reg} + 9'd1 : {1'b0, root_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LS_IDLE:   if (ctrl.start) state_next = LS_SQUARE;
            LS_SQUARE: state_next = LS_ROOT;
            LS_ROOT:   if (cnt_reg == STEP_W'(ROOT_STEPS - 1)) state_next = LS_DONE;
            LS_DONE:   if (ctrl.ack) state_next = LS_IDLE;
            default:   state_next = LS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LS_IDLE:
            begin
                gx_reg <= gx_c;
                gy_reg <= gy_c;
            end
            LS_SQUARE:
            begin
                sat_reg  <= sq_c > SAT_LIMIT;
                rad_reg  <= sq_c[15:0];
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            LS_ROOT:
            begin
                // one result bit per cycle
                rad_reg <= {rad_reg[13:0], 2'b00};
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (rem_sh >= trial)
                begin
                    rem_reg  <= 10'(rem_sh - trial);
                    root_reg <= {root_reg[CH_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[9:0];
                    root_reg <= {root_reg[CH_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign stat.done = (state_reg == LS_DONE);
    assign stat.mag  = sat_reg ? MAG_MAX : rounded[CH_W-1:0];

endmodule

`default_nettype wire

[design/sobel_edge_magnitude_rgb.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Streaming Sobel edge magnitude on RGB pixels in raster order. Each pixel
// beat yields, image_width+1 positions later, one beat with
// round(sqrt(Gx^2+Gy^2)) per channel clamped to 255, pixels outside the
// frame counted as zero. After the last pixel of a frame, send drain beats
// (tuser = 1) to flush the remaining results; tlast marks the frame's final
// result, after which a new frame starts. Drains at other times are dropped.
// A pixel beat first reads the line store; as the read step ends the window
// updates while the three channel lanes latch their gradients in parallel,
// then the lanes square, run 8 square-root steps at one result bit per cycle
// and hand off to the output register. A beat that yields no result returns
// to idle after the read; no new beat is taken while the lanes are busy.
// Results sit in an output register, so the next beat is taken while a
// finished result waits. Writing a register restarts the frame; write it
// only while the block is idle.
module sobel_edge_magnitude_rgb (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red_out, green_out, blue_out
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sem_pkg::*;

    top_state_t          state_reg, state_next;
    logic [WREG_W-1:0]   width_reg;
    logic [HREG_W-1:0]   height_reg;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    pixel_t              win_reg [WIN_N];
    pixel_t              win_next [WIN_N];
    pixel_t              mag_win [WIN_N];
    pixel_t              pix_reg;
    logic                last_reg;
    logic                m_valid_reg;
    logic [23:0]         m_data_reg;
    logic                m_last_reg;

    logic [WREG_W-1:0]   eff_w;
    logic [ROW_W-1:0]    eff_h;
    logic                cfg_wr;
    logic                restart;
    logic                accept;
    logic                pending;
    logic                take;
    pixel_t              rd_prev, rd_old;
    pixel_t              c_old, c_prev, c_new;
    logic                emit;
    logic [ROW_W-1:0]    orow;
    logic [WREG_W-1:0]   ocol;
    logic                last_c;
    logic                out_free;
    logic                load_out;
    lane_ctrl_t          lane_ctrl;
    lane_stat_t          lane_stat [3];
    logic [CH_W-1:0]     lane_taps [3][WIN_N];

    // Clamp out-of-range sizes
    assign eff_w = (width_reg == '0) ? WREG_W'(1) :
                   (width_reg > WREG_W'(MAX_WIDTH)) ? WREG_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (height_reg == '0) ? ROW_W'(1) :
                   (height_reg > HREG_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : height_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_IMAGE_WIDTH:  prdata = {21'b0, width_reg};
            ADDR_IMAGE_HEIGHT: prdata = {19'b0, height_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_IMAGE_WIDTH:  width_reg  <= pwdata[WREG_W-1:0];
                ADDR_IMAGE_HEIGHT: height_reg <= pwdata[HREG_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = cfg_wr && (paddr == ADDR_IMAGE_WIDTH || paddr == ADDR_IMAGE_HEIGHT);

    // Input side: a drain before the frame is complete is dropped at once
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pending  = (in_row_reg >= eff_h);
    assign take     = accept && (!s_tuser || pending);

    sem_line_store u_line_store (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (in_col_reg),
        .wr_prev (c_new),
        .wr_old  (rd_prev),
        .rd_prev (rd_prev),
        .rd_old  (rd_old)
    );

    // Window update; rows not yet written in this frame read as zero
    always_comb
    begin
        c_old  = ((in_row_reg >= ROW_W'(2)) &&
                  ({1'b0, in_row_reg} < {1'b0, eff_h} + (ROW_W + 1)'(2))) ? rd_old : '0;
        c_prev = ((in_row_reg >= ROW_W'(1)) &&
                  ({1'b0, in_row_reg} < {1'b0, eff_h} + (ROW_W + 1)'(1))) ? rd_prev : '0;
        c_new  = pending ? '0 : pix_reg;

        for (int r = 0; r < 3; r++)
        begin
            mag_win[r*3]     = win_reg[r*3+1];
            mag_win[r*3 + 1] = win_reg[r*3+2];
        end
        if (in_col_reg == '0)
        begin
            mag_win[2] = '0;
            mag_win[5] = '0;
            mag_win[8] = '0;
            for (int k = 0; k < WIN_N; k++)
                win_next[k] = '0;
            win_next[2] = c_old;
            win_next[5] = c_prev;
            win_next[8] = c_new;
        end
        else
        begin
            mag_win[2] = c_old;
            mag_win[5] = c_prev;
            mag_win[8] = c_new;
            win_next = mag_win;
        end

        emit = (in_row_reg > ROW_W'(1)) || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        if (in_col_reg == '0)
        begin
            orow = in_row_reg - ROW_W'(2);
            ocol = eff_w - WREG_W'(1);
        end
        else
        begin
            orow = in_row_reg - ROW_W'(1);
            ocol = WREG_W'(in_col_reg) - WREG_W'(1);
        end
        last_c = (orow == eff_h - ROW_W'(1)) && (ocol == eff_w - WREG_W'(1));

        // Advance the input position
        if (WREG_W'(in_col_reg) + WREG_W'(1) >= eff_w)
        begin
            in_col_next = '0;
            in_row_next = in_row_reg + ROW_W'(1);
        end
        else
        begin
            in_col_next = in_col_reg + COL_W'(1);
            in_row_next = in_row_reg;
        end
    end

    // Sequencer
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_WAIT) && lane_stat[0].done && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = ST_READ;
            ST_READ: state_next = emit ? ST_WAIT : ST_IDLE;
            ST_WAIT: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            in_col_reg <= '0;
            in_row_reg <= '0;
            for (int k = 0; k < WIN_N; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                for (int k = 0; k < WIN_N; k++)
                    win_reg[k] <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                if (emit && last_c)
                begin
                    // frame done: start over
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    for (int k = 0; k < WIN_N; k++)
                        win_reg[k] <= '0;
                end
                else
                begin
                    in_col_reg <= in_col_next;
                    in_row_reg <= in_row_next;
                    win_reg    <= win_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            pix_reg <= s_tdata;
        if (state_reg == ST_READ)
            last_reg <= last_c;
    end

    // Channel lanes: red, green, blue
    assign lane_ctrl.start = (state_reg == ST_READ) && emit;
    assign lane_ctrl.ack   = load_out;

    always_comb
    begin
        for (int k = 0; k < WIN_N; k++)
        begin
            lane_taps[0][k] = mag_win[k][7:0];
            lane_taps[1][k] = mag_win[k][15:8];
            lane_taps[2][k] = mag_win[k][23:16];
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        sem_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .taps  (lane_taps[g]),
            .stat  (lane_stat[g])
        );
    end

    // Merge the lane results into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= {lane_stat[2].mag, lane_stat[1].mag, lane_stat[0].mag};
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SEM_ASSERT_IMP(a_lanes_lockstep, 1'b1,
        lane_stat[0].done == lane_stat[1].done && lane_stat[0].done == lane_stat[2].done,
        "channel lanes out of step")
    `SEM_ASSERT_NXT(a_take_reads, take, state_reg == ST_READ,
        "accepted beat did not go to the read step")
    `SEM_ASSERT_IMP(a_load_from_wait, $rose(m_valid_reg), $past(state_reg == ST_WAIT),
        "output loaded outside the wait step")
    `SEM_ASSERT_NXT(a_no_result_idle, state_reg == ST_READ && !emit, state_reg == ST_IDLE,
        "beat without result did not return to idle")

endmodule

`default_nettype wire
